>>> rtl/core/fixed_timestep_frame_pacer_unit_defines.svh
// Assertion macros for the fixed-timestep frame pacer.
// Used by fixed_timestep_frame_pacer_unit.sv; no other dependencies.
`ifndef FIXED_TIMESTEP_FRAME_PACER_UNIT_DEFINES_SVH
`define FIXED_TIMESTEP_FRAME_PACER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define FTFP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define FTFP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ftfp_pkg.sv
// Shared types and constants for the fixed-timestep frame pacer.
// No dependencies; imported by fixed_timestep_frame_pacer_unit.
`default_nettype none

package ftfp_pkg;

    // timestamp width, wraps modulo 2^TIME_BITS
    localparam int TIME_BITS = 48;

    // field and state widths
    localparam int REG_W   = 20;
    localparam int BANK_W  = 21;
    localparam int COUNT_W = 16;
    localparam int RATE_W  = 24;
    localparam int PROD_W  = COUNT_W + REG_W;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = PROD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // configuration port
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DELTA        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WINDOW       = 2'd3;

    // reset values of the configuration registers
    localparam logic [REG_W-1:0] FRAME_PERIOD_RST     = 20'd16667;
    localparam logic [REG_W-1:0] MAX_DELTA_RST        = 20'd250000;
    localparam logic [REG_W-1:0] TICKS_PER_SECOND_RST = 20'd1000000;
    localparam logic [REG_W-1:0] MIN_WINDOW_RST       = 20'd100000;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    // saturation limits
    localparam logic [BANK_W-1:0]  BANK_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

    // request item
    typedef struct packed {
        logic                 req_type;
        logic [TIME_BITS-1:0] now_ticks;
    } ftfp_req_t;

    // result item
    typedef struct packed {
        logic              update_due;
        logic [RATE_W-1:0] rate_q8;
    } ftfp_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/fixed_timestep_frame_pacer_unit.sv
// Fixed-timestep frame pacer with frame-rate meter: top level.
// Depends on ftfp_pkg and fixed_timestep_frame_pacer_unit_defines.svh.
//
//   channel  signals                      direction  item
//   req      req_valid req_stall req      in         ftfp_req_t (start or poll)
//   rsp      rsp_valid rsp_stall rsp      out        ftfp_rsp_t (update flag, rate)
//   cfg      cfg_wr_en cfg_index cfg_data in         20-bit register write
//
// A start item passes the delta and done steps, a poll without a frame the delta, bank,
// frame and done steps. A poll that recomputes the rate also passes the window step and
// the divider, one quotient bit per cycle (44 bits) through a single subtractor.
// One item is worked at a time; req_stall is high until the result reaches the
// output register, which holds it while rsp_stall is high; a next item then waits in done.
// Reset loads the register defaults and clears all pacing state; no clearing pass.
`default_nettype none

`include "fixed_timestep_frame_pacer_unit_defines.svh"

module fixed_timestep_frame_pacer_unit
    import ftfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire ftfp_req_t              req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output ftfp_rsp_t                   rsp,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]       cfg_data
);

    // sequencer states
    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STATE_W-1:0] S_DELTA    = 4'd1;
    localparam logic [STATE_W-1:0] S_BANK     = 4'd2;
    localparam logic [STATE_W-1:0] S_FRAME    = 4'd3;
    localparam logic [STATE_W-1:0] S_WIN      = 4'd4;
    localparam logic [STATE_W-1:0] S_DIV_INIT = 4'd5;
    localparam logic [STATE_W-1:0] S_DIV_RUN  = 4'd6;
    localparam logic [STATE_W-1:0] S_DIV_END  = 4'd7;
    localparam logic [STATE_W-1:0] S_DONE     = 4'd8;

    // control and architectural state
    logic [STATE_W-1:0]   state_reg, state_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [REG_W-1:0]     frame_period_reg, frame_period_next;
    logic [REG_W-1:0]     max_delta_reg, max_delta_next;
    logic [REG_W-1:0]     tps_reg, tps_next;
    logic [REG_W-1:0]     min_window_reg, min_window_next;
    logic [TIME_BITS-1:0] prev_time_reg, prev_time_next;
    logic [BANK_W-1:0]    bank_reg, bank_next;
    logic [COUNT_W-1:0]   frames_reg, frames_next;
    logic [TIME_BITS-1:0] win_start_reg, win_start_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;

    // working registers of the current item
    logic                 req_type_reg, req_type_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [REG_W-1:0]     delta_reg, delta_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 due_reg, due_next;
    ftfp_rsp_t            rsp_reg, rsp_next;

    // datapath helpers
    logic                 req_accept;
    logic                 rsp_take;
    logic [TIME_BITS-1:0] time_diff;
    logic [BANK_W:0]      bank_sum;
    logic [TIME_BITS:0]   rem_shift;
    logic [TIME_BITS+1:0] rem_diff;
    logic                 rem_ge;

    assign req_accept = req_valid && !req_stall;
    assign rsp_take   = rsp_valid_reg && !rsp_stall;
    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // shared time subtractor: step since previous item, or window age
    always_comb
    begin
        if (state_reg == S_DELTA)
        begin
            time_diff = now_reg - prev_time_reg;
        end
        else
        begin
            time_diff = now_reg - win_start_reg;
        end
    end

    // bank accumulate, one bit wider to catch saturation
    assign bank_sum = {1'b0, bank_reg} + {{(BANK_W + 1 - REG_W){1'b0}}, delta_reg};

    // restoring division step
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, elapsed_reg};
    assign rem_ge    = !rem_diff[TIME_BITS+1];

    // sequencer and next-state logic
    always_comb
    begin
        state_next        = state_reg;
        rsp_valid_next    = rsp_valid_reg;
        frame_period_next = frame_period_reg;
        max_delta_next    = max_delta_reg;
        tps_next          = tps_reg;
        min_window_next   = min_window_reg;
        prev_time_next    = prev_time_reg;
        bank_next         = bank_reg;
        frames_next       = frames_reg;
        win_start_next    = win_start_reg;
        rate_next         = rate_reg;
        req_type_next     = req_type_reg;
        now_next          = now_reg;
        delta_next        = delta_reg;
        elapsed_next      = elapsed_reg;
        prod_next         = prod_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        due_next          = due_reg;
        rsp_next          = rsp_reg;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_PERIOD:     frame_period_next = cfg_data;
                REG_MAX_DELTA:        max_delta_next    = cfg_data;
                REG_TICKS_PER_SECOND: tps_next          = cfg_data;
                REG_MIN_WINDOW:       min_window_next   = cfg_data;
                default:              ;
            endcase
        end

        // output register drains independently of the sequencer
        if (rsp_take)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    req_type_next = req.req_type;
                    now_next      = req.now_ticks;
                    state_next    = S_DELTA;
                end
            end

            // start restarts the pacing state; poll takes the clamped step
            S_DELTA:
            begin
                due_next       = 1'b0;
                prev_time_next = now_reg;
                if (req_type_reg == REQ_START)
                begin
                    win_start_next = now_reg;
                    bank_next      = '0;
                    frames_next    = '0;
                    rate_next      = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    if ((|time_diff[TIME_BITS-1:REG_W]) || (time_diff[REG_W-1:0] > max_delta_reg))
                    begin
                        delta_next = max_delta_reg;
                    end
                    else
                    begin
                        delta_next = time_diff[REG_W-1:0];
                    end
                    state_next = S_BANK;
                end
            end

            // saturating bank add
            S_BANK:
            begin
                if (bank_sum[BANK_W])
                begin
                    bank_next = BANK_MAX;
                end
                else
                begin
                    bank_next = bank_sum[BANK_W-1:0];
                end
                state_next = S_FRAME;
            end

            // if a period is banked, remove it and count a frame
            S_FRAME:
            begin
                if (bank_reg >= {1'b0, frame_period_reg})
                begin
                    bank_next    = bank_reg - {1'b0, frame_period_reg};
                    due_next     = 1'b1;
                    elapsed_next = time_diff;
                    if (frames_reg != COUNT_MAX)
                    begin
                        frames_next = frames_reg + 1'b1;
                    end
                    state_next = S_WIN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // window decision and numerator product
            S_WIN:
            begin
                prod_next = {{(PROD_W - COUNT_W){1'b0}}, frames_reg}
                          * {{(PROD_W - REG_W){1'b0}}, tps_reg};
                if (elapsed_reg >= {{(TIME_BITS - REG_W){1'b0}}, tps_reg})
                begin
                    frames_next    = '0;
                    win_start_next = now_reg;
                    state_next     = S_DIV_INIT;
                end
                else if (elapsed_reg > {{(TIME_BITS - REG_W){1'b0}}, min_window_reg})
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // load divider, zero divisor handled here
            S_DIV_INIT:
            begin
                if (elapsed_reg == '0)
                begin
                    rate_next  = (prod_reg != '0) ? RATE_MAX : '0;
                    state_next = S_DONE;
                end
                else
                begin
                    quo_next   = {prod_reg, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = DIV_CNT_W'(NUM_W - 1);
                    state_next = S_DIV_RUN;
                end
            end

            // one quotient bit per cycle
            S_DIV_RUN:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_diff[TIME_BITS-1:0];
                end
                else
                begin
                    rem_next = rem_shift[TIME_BITS-1:0];
                end
                quo_next = {quo_reg[NUM_W-2:0], rem_ge};
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // saturate quotient to rate width
            S_DIV_END:
            begin
                if (|quo_reg[NUM_W-1:RATE_W])
                begin
                    rate_next = RATE_MAX;
                end
                else
                begin
                    rate_next = quo_reg[RATE_W-1:0];
                end
                state_next = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.update_due = due_reg;
                    rsp_next.rate_q8    = rate_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            frame_period_reg <= FRAME_PERIOD_RST;
            max_delta_reg    <= MAX_DELTA_RST;
            tps_reg          <= TICKS_PER_SECOND_RST;
            min_window_reg   <= MIN_WINDOW_RST;
            prev_time_reg    <= '0;
            bank_reg         <= '0;
            frames_reg       <= '0;
            win_start_reg    <= '0;
            rate_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            frame_period_reg <= frame_period_next;
            max_delta_reg    <= max_delta_next;
            tps_reg          <= tps_next;
            min_window_reg   <= min_window_next;
            prev_time_reg    <= prev_time_next;
            bank_reg         <= bank_next;
            frames_reg       <= frames_next;
            win_start_reg    <= win_start_next;
            rate_reg         <= rate_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        now_reg      <= now_next;
        delta_reg    <= delta_next;
        elapsed_reg  <= elapsed_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        due_reg      <= due_next;
        rsp_reg      <= rsp_next;
    end

    // checks
    `FTFP_ASSERT_NXT(a_accept_starts_work, clk, rst_n, req_accept, state_reg == S_DELTA, "accepted item did not start the sequencer")
    `FTFP_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == S_DONE, "result appeared outside the done step")
    `FTFP_ASSERT_IMP(a_update_only_on_poll, clk, rst_n, (state_reg == S_DONE) && due_reg, req_type_reg == REQ_POLL, "update flagged for a start item")
    `FTFP_ASSERT_IMP(a_divisor_nonzero, clk, rst_n, state_reg == S_DIV_RUN, elapsed_reg != '0, "divider running with zero divisor")

endmodule

`default_nettype wire
